// File: sv/fcea_pkg.sv
// ----------------------------------------------------------------------------
// fcea_pkg
// Types and constants shared by the Fock Coulomb/exchange accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package fcea_pkg;

    localparam int MAX_BASIS   = 64;
    localparam int FRAC_BITS   = 24;
    localparam int IDX_W       = $clog2(MAX_BASIS);
    localparam int BASIS_W     = 7;
    localparam int ADDR_W      = 2 * IDX_W;
    localparam int STORE_DEPTH = MAX_BASIS * MAX_BASIS;

    localparam int VAL_W  = 40;
    localparam int HALF_W = VAL_W / 2;
    localparam int PP_W   = 2 * HALF_W;
    localparam int PROD_W = 2 * VAL_W;
    localparam int TERM_W = VAL_W + 2;
    localparam int SUM_W  = VAL_W + 4;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic [TERM_W-1:0] TERM_LIMIT = {1'b1, {(TERM_W-1){1'b0}}};

    localparam logic signed [SUM_W-1:0] VAL_MAX_S =
        {{(SUM_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] VAL_MIN_S =
        {{(SUM_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

    localparam logic [PROD_W-1:0] REM_MASK_COUL = (PROD_W'(1) << (FRAC_BITS - 1)) - PROD_W'(1);
    localparam logic [PROD_W-1:0] REM_MASK_EXCH = (PROD_W'(1) << FRAC_BITS) - PROD_W'(1);

    localparam logic [BASIS_W-1:0] BASIS_RESET = BASIS_W'(MAX_BASIS);

    localparam logic REG_BASIS_SIZE = 1'b0;

    localparam logic [1:0] FUNC_WR_DENSITY = 2'd0;
    localparam logic [1:0] FUNC_WR_FOCK    = 2'd1;
    localparam logic [1:0] FUNC_CONTRACT   = 2'd2;
    localparam logic [1:0] FUNC_RD_FOCK    = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIMPLE,
        ST_RD_FOCK,
        ST_RD_OUT,
        ST_FETCH,
        ST_MAG,
        ST_MUL,
        ST_TERM,
        ST_WB
    } state_t;

endpackage

`default_nettype wire

// File: sv/fock_coulomb_exchange_accumulate_core.sv
// ----------------------------------------------------------------------------
// fock_coulomb_exchange_accumulate_core
// Density and Fock stores with a sequenced Coulomb/exchange update that
// shares one 20x20 multiplier and one saturating adder.
// ----------------------------------------------------------------------------
// Sequence: writes and index errors go IDLE, SIMPLE; Fock reads go IDLE,
// RD_FOCK, RD_OUT; done is registered from the last state of each item.
// A new item is taken only when idle; a contraction runs two passes of
// fetch, partial-product multiply, round and read-modify-write.
// Reset: stores are not cleared; basis_size returns to 64, sequencer idles.
// The receiver cannot stall: each result is shown for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fock_coulomb_exchange_accumulate_core
    import fcea_pkg::*;
(
    input  wire                          clk,
    input  wire                          rst_n,

    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [CFG_ADDR_W-1:0]        paddr,
    input  wire  [CFG_DATA_W-1:0]        pwdata,
    output logic [CFG_DATA_W-1:0]        prdata,
    output logic                         pready,

    input  wire                          start,
    output logic                         busy,
    input  wire  [1:0]                   func,
    input  wire  [IDX_W-1:0]             index_i,
    input  wire  [IDX_W-1:0]             index_j,
    input  wire  [IDX_W-1:0]             index_k,
    input  wire  [IDX_W-1:0]             index_l,
    input  wire  signed [VAL_W-1:0]      value_in,

    output logic                         done,
    output logic signed [VAL_W-1:0]      fock_value,
    output logic                         index_error,
    output logic                         saturated
);

    state_t state_reg, state_next;

    logic [BASIS_W-1:0] basis_size_reg;
    logic               phase_reg, phase_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               sat_reg, sat_next;
    logic               err_reg, err_next;
    logic               done_reg, done_next;

    logic [1:0]         func_reg, func_next;
    logic [IDX_W-1:0]   i_reg, i_next, j_reg, j_next, k_reg, k_next, l_reg, l_next;
    logic [VAL_W-1:0]   value_reg, value_next;
    logic [VAL_W-1:0]   b_mag_reg, b_mag_next;
    logic               b_neg_reg, b_neg_next;
    logic [VAL_W-1:0]   a_mag_reg, a_mag_next;
    logic               neg_reg, neg_next;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [TERM_W-1:0]  term_reg, term_next;

    logic [VAL_W-1:0]   fock_value_reg, fock_value_next;
    logic               index_error_reg, index_error_next;
    logic               saturated_reg, saturated_next;

    logic [VAL_W-1:0]   den_mem [STORE_DEPTH];
    logic [VAL_W-1:0]   fock_mem [STORE_DEPTH];
    logic [VAL_W-1:0]   den_rdata_reg, fock_rdata_reg;
    logic [ADDR_W-1:0]  den_addr, fock_addr;
    logic               den_we, den_re, fock_we, fock_re;
    logic [VAL_W-1:0]   fock_wdata;

    logic               accept;
    logic               cfg_write;
    logic               err_in;

    logic [HALF_W-1:0]  a_half, b_half;
    logic [PP_W-1:0]    pp;
    logic [PROD_W-1:0]  pp_shifted;
    logic [PROD_W-1:0]  q_full, q_round;
    logic               round_up;
    logic signed [SUM_W-1:0] fock_ext, term_ext, sum;
    logic               clip_hi, clip_lo;
    logic [VAL_W-1:0]   clipped;

    function automatic logic idx_ok(input logic [IDX_W-1:0] x, input logic [BASIS_W-1:0] n);
        idx_ok = ({1'b0, x} < n) && ({1'b0, x} < BASIS_W'(MAX_BASIS));
    endfunction

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_BASIS_SIZE);
    assign prdata    = (paddr[2] == REG_BASIS_SIZE) ? CFG_DATA_W'(basis_size_reg)
                                                     : '0;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign err_in = (func == FUNC_CONTRACT)
        ? !(idx_ok(index_i, basis_size_reg) && idx_ok(index_j, basis_size_reg) &&
            idx_ok(index_k, basis_size_reg) && idx_ok(index_l, basis_size_reg))
        : !(idx_ok(index_i, basis_size_reg) && idx_ok(index_j, basis_size_reg));

    // addresses: row-major, MAX_BASIS a power of two
    always_comb
    begin
        priority if (func_reg == FUNC_CONTRACT && !phase_reg)
        begin
            den_addr = {k_reg, l_reg};
        end
        else if (func_reg == FUNC_CONTRACT)
        begin
            den_addr = {i_reg, l_reg};
        end
        else
        begin
            den_addr = {i_reg, j_reg};
        end
        fock_addr = phase_reg ? {j_reg, k_reg} : {i_reg, j_reg};
    end

    // shared multiplier: one 20x20 partial product per cycle
    assign a_half = cnt_reg[0] ? a_mag_reg[VAL_W-1:HALF_W] : a_mag_reg[HALF_W-1:0];
    assign b_half = cnt_reg[1] ? b_mag_reg[VAL_W-1:HALF_W] : b_mag_reg[HALF_W-1:0];
    assign pp     = a_half * b_half;

    always_comb
    begin
        unique case (cnt_reg)
            2'd0:       pp_shifted = {{(PROD_W-PP_W){1'b0}}, pp};
            2'd1, 2'd2: pp_shifted = {{(PROD_W-PP_W-HALF_W){1'b0}}, pp, {HALF_W{1'b0}}};
            default:    pp_shifted = {pp, {(PROD_W-PP_W){1'b0}}};
        endcase
    end

    // floor rounding of the shifted product
    assign q_full   = phase_reg ? (acc_reg >> FRAC_BITS) : (acc_reg >> (FRAC_BITS - 1));
    assign round_up = neg_reg &&
        (|(acc_reg & (phase_reg ? REM_MASK_EXCH : REM_MASK_COUL)));
    assign q_round  = q_full + PROD_W'(round_up);

    // saturating accumulate; exchange term is subtracted
    assign fock_ext = SUM_W'($signed(fock_rdata_reg));
    assign term_ext = $signed({{(SUM_W-TERM_W){1'b0}}, term_reg});
    assign sum      = (neg_reg ^ phase_reg) ? (fock_ext - term_ext) : (fock_ext + term_ext);
    assign clip_hi  = (sum > VAL_MAX_S);
    assign clip_lo  = (sum < VAL_MIN_S);

    always_comb
    begin
        priority if (clip_hi)
        begin
            clipped = VAL_MAX_S[VAL_W-1:0];
        end
        else if (clip_lo)
        begin
            clipped = VAL_MIN_S[VAL_W-1:0];
        end
        else
        begin
            clipped = sum[VAL_W-1:0];
        end
    end

    assign fock_wdata = (func_reg == FUNC_WR_FOCK) ? value_reg : clipped;

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        cnt_next         = cnt_reg;
        sat_next         = sat_reg;
        err_next         = err_reg;
        done_next        = 1'b0;
        func_next        = func_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        k_next           = k_reg;
        l_next           = l_reg;
        value_next       = value_reg;
        b_mag_next       = b_mag_reg;
        b_neg_next       = b_neg_reg;
        a_mag_next       = a_mag_reg;
        neg_next         = neg_reg;
        acc_next         = acc_reg;
        term_next        = term_reg;
        fock_value_next  = fock_value_reg;
        index_error_next = index_error_reg;
        saturated_next   = saturated_reg;
        den_we           = 1'b0;
        den_re           = 1'b0;
        fock_we          = 1'b0;
        fock_re          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next  = func;
                    i_next     = index_i;
                    j_next     = index_j;
                    k_next     = index_k;
                    l_next     = index_l;
                    value_next = value_in;
                    b_neg_next = value_in[VAL_W-1];
                    b_mag_next = value_in[VAL_W-1] ? (~value_in + VAL_W'(1)) : value_in;
                    err_next   = err_in;
                    phase_next = 1'b0;
                    sat_next   = 1'b0;
                    priority if (err_in || func == FUNC_WR_DENSITY || func == FUNC_WR_FOCK)
                    begin
                        state_next = ST_SIMPLE;
                    end
                    else if (func == FUNC_RD_FOCK)
                    begin
                        state_next = ST_RD_FOCK;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_SIMPLE:
            begin
                den_we           = !err_reg && (func_reg == FUNC_WR_DENSITY);
                fock_we          = !err_reg && (func_reg == FUNC_WR_FOCK);
                done_next        = 1'b1;
                fock_value_next  = '0;
                index_error_next = err_reg;
                saturated_next   = 1'b0;
                state_next       = ST_IDLE;
            end
            ST_RD_FOCK:
            begin
                fock_re    = 1'b1;
                state_next = ST_RD_OUT;
            end
            ST_RD_OUT:
            begin
                done_next        = 1'b1;
                fock_value_next  = fock_rdata_reg;
                index_error_next = 1'b0;
                saturated_next   = 1'b0;
                state_next       = ST_IDLE;
            end
            ST_FETCH:
            begin
                den_re     = 1'b1;
                fock_re    = 1'b1;
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                a_mag_next = den_rdata_reg[VAL_W-1] ? (~den_rdata_reg + VAL_W'(1))
                                                    : den_rdata_reg;
                neg_next   = den_rdata_reg[VAL_W-1] ^ b_neg_reg;
                acc_next   = '0;
                cnt_next   = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                acc_next = acc_reg + pp_shifted;
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = ST_TERM;
                end
            end
            ST_TERM:
            begin
                term_next  = (q_round > PROD_W'(TERM_LIMIT)) ? TERM_LIMIT
                                                             : q_round[TERM_W-1:0];
                state_next = ST_WB;
            end
            ST_WB:
            begin
                fock_we  = 1'b1;
                sat_next = sat_reg || clip_hi || clip_lo;
                if (phase_reg)
                begin
                    done_next        = 1'b1;
                    fock_value_next  = '0;
                    index_error_next = 1'b0;
                    saturated_next   = sat_reg || clip_hi || clip_lo;
                    phase_next       = 1'b0;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    phase_next = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            basis_size_reg <= BASIS_RESET;
            phase_reg      <= 1'b0;
            cnt_reg        <= '0;
            sat_reg        <= 1'b0;
            err_reg        <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            sat_reg   <= sat_next;
            err_reg   <= err_next;
            done_reg  <= done_next;
            if (cfg_write)
            begin
                basis_size_reg <= pwdata[BASIS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        i_reg           <= i_next;
        j_reg           <= j_next;
        k_reg           <= k_next;
        l_reg           <= l_next;
        value_reg       <= value_next;
        b_mag_reg       <= b_mag_next;
        b_neg_reg       <= b_neg_next;
        a_mag_reg       <= a_mag_next;
        neg_reg         <= neg_next;
        acc_reg         <= acc_next;
        term_reg        <= term_next;
        fock_value_reg  <= fock_value_next;
        index_error_reg <= index_error_next;
        saturated_reg   <= saturated_next;
    end

    // single-port stores, registered read
    always_ff @(posedge clk)
    begin
        if (den_we)
        begin
            den_mem[den_addr] <= value_reg;
        end
        if (den_re)
        begin
            den_rdata_reg <= den_mem[den_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fock_we)
        begin
            fock_mem[fock_addr] <= fock_wdata;
        end
        if (fock_re)
        begin
            fock_rdata_reg <= fock_mem[fock_addr];
        end
    end

    assign done        = done_reg;
    assign fock_value  = fock_value_reg;
    assign index_error = index_error_reg;
    assign saturated   = saturated_reg;

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Fock Coulomb/exchange accumulator. Items go in
// on the start/busy handshake and an item-level model of the density and
// Fock stores predicts each result, compared field by field at the done
// strobe. Directed corners come first, then random traffic under several
// basis sizes set over the APB port, including zero and oversized.
// ----------------------------------------------------------------------------
module testbench;
    import fcea_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 10;

    localparam logic [CFG_ADDR_W-1:0] BASIS_SIZE_ADDR = CFG_ADDR_W'(4 * int'(REG_BASIS_SIZE));

    localparam logic signed [VAL_W-1:0] FIX_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] FIX_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] FIX_ONE = VAL_W'(1) << FRAC_BITS;
    localparam logic signed [PROD_W-1:0] TERM_CAP = PROD_W'(1) << (VAL_W + 1);
    localparam longint FOCK_HI = (64'sd1 <<< (VAL_W - 1)) - 1;
    localparam longint FOCK_LO = -(64'sd1 <<< (VAL_W - 1));

    typedef struct packed {
        logic [VAL_W-1:0] fock;
        logic             err;
        logic             sat;
    } fock_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]   paddr = '0;
    logic [CFG_DATA_W-1:0]   pwdata = '0;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    start = 1'b0;
    logic                    busy;
    logic [1:0]              func = FUNC_WR_DENSITY;
    logic [IDX_W-1:0]        index_i = '0;
    logic [IDX_W-1:0]        index_j = '0;
    logic [IDX_W-1:0]        index_k = '0;
    logic [IDX_W-1:0]        index_l = '0;
    logic signed [VAL_W-1:0] value_in = '0;
    logic                    done;
    logic signed [VAL_W-1:0] fock_value;
    logic                    index_error;
    logic                    saturated;

    fock_coulomb_exchange_accumulate_core dut (.*);

    always #10 clk = ~clk;

    logic signed [VAL_W-1:0] dens_mem [STORE_DEPTH];
    logic signed [VAL_W-1:0] fock_mem [STORE_DEPTH];
    bit                      dens_set [STORE_DEPTH];
    bit                      fock_set [STORE_DEPTH];
    logic [BASIS_W-1:0]      basis_cfg = BASIS_RESET;

    fock_result_t pending_results [$];
    logic [IDX_W-1:0] hot_idx [6];
    bit no_gaps = 1'b0;
    int n_errors = 0;
    int n_items = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_contract = 0;
    int n_reads = 0;
    int n_idx_err = 0;
    int n_sat = 0;

    function automatic void flag_error(string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("MISMATCH @%0t: %s", $time, msg);
    endfunction

    function automatic bit idx_valid(logic [IDX_W-1:0] x);
        return int'(x) < int'(basis_cfg) && int'(x) < MAX_BASIS;
    endfunction

    // floor(d*g / 2^shift), magnitude capped at 2^41
    function automatic longint scaled_product(logic signed [VAL_W-1:0] d,
                                              logic signed [VAL_W-1:0] g, int shift);
        logic signed [PROD_W-1:0] d_w, g_w, q;
        d_w = PROD_W'(d);
        g_w = PROD_W'(g);
        q = (d_w * g_w) >>> shift;
        if (q > TERM_CAP)
            q = TERM_CAP;
        else if (q < -TERM_CAP)
            q = -TERM_CAP;
        return longint'(q);
    endfunction

    function automatic logic signed [VAL_W-1:0] clip_fock(longint s, inout logic sat);
        if (s > FOCK_HI) begin
            sat = 1'b1;
            return FOCK_HI[VAL_W-1:0];
        end
        if (s < FOCK_LO) begin
            sat = 1'b1;
            return FOCK_LO[VAL_W-1:0];
        end
        return s[VAL_W-1:0];
    endfunction

    function automatic fock_result_t apply_item(logic [1:0] op, logic [IDX_W-1:0] i, j, k, l,
                                                logic signed [VAL_W-1:0] v);
        fock_result_t r;
        logic [ADDR_W-1:0] a_ij, a_jk;
        longint coul, exch;
        logic sat;
        bit ok;
        r = '0;
        sat = 1'b0;
        a_ij = {i, j};
        a_jk = {j, k};
        if (op == FUNC_CONTRACT)
            ok = idx_valid(i) && idx_valid(j) && idx_valid(k) && idx_valid(l);
        else
            ok = idx_valid(i) && idx_valid(j);
        r.err = !ok;
        if (!ok)
            n_idx_err++;
        else begin
            case (op)
                FUNC_WR_DENSITY:
                begin
                    dens_mem[a_ij] = v;
                    dens_set[a_ij] = 1'b1;
                end
                FUNC_WR_FOCK:
                begin
                    fock_mem[a_ij] = v;
                    fock_set[a_ij] = 1'b1;
                end
                FUNC_RD_FOCK:
                begin
                    r.fock = fock_mem[a_ij];
                    n_reads++;
                end
                default:
                begin
                    // Coulomb first; exchange sees it when both hit one entry
                    coul = scaled_product(dens_mem[{k, l}], v, FRAC_BITS - 1);
                    fock_mem[a_ij] = clip_fock(fock_mem[a_ij] + coul, sat);
                    exch = scaled_product(dens_mem[{i, l}], v, FRAC_BITS);
                    fock_mem[a_jk] = clip_fock(fock_mem[a_jk] - exch, sat);
                    r.sat = sat;
                    n_contract++;
                    if (sat)
                        n_sat++;
                end
            endcase
        end
        return r;
    endfunction

    always @(posedge clk)
    begin : result_check
        fock_result_t want;
        if (rst_n) begin
            if (done) begin
                if (pending_results.size() == 0)
                    flag_error("result strobe with no item outstanding");
                else begin
                    want = pending_results.pop_front();
                    n_checked++;
                    if (fock_value !== want.fock || index_error !== want.err
                            || saturated !== want.sat)
                        flag_error($sformatf(
                            "fock_value %h/%h index_error %b/%b saturated %b/%b (exp/act)",
                            want.fock, fock_value, want.err, index_error,
                            want.sat, saturated));
                end
            end
            if (psel && penable && pwrite && pready && paddr == BASIS_SIZE_ADDR)
                basis_cfg = pwdata[BASIS_W-1:0];
            if (start && !busy) begin
                pending_results.push_back(apply_item(func, index_i, index_j, index_k,
                                                     index_l, value_in));
                n_items++;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        int idle;
        if (!rst_n || (start && !busy) || done || (psel && penable))
            idle = 0;
        else
            idle++;
        if (idle >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic issue_op(logic [1:0] op, logic [IDX_W-1:0] i, j, k, l,
                            logic signed [VAL_W-1:0] v);
        int gap;
        if ($urandom_range(0, 29) == 0)
            no_gaps = !no_gaps;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        func <= op;
        index_i <= i;
        index_j <= j;
        index_k <= k;
        index_l <= l;
        value_in <= v;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        n_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0 || busy)
            @(negedge clk);
    endtask

    task automatic check_basis(logic [BASIS_W-1:0] size);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        paddr <= BASIS_SIZE_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== CFG_DATA_W'(size))
            flag_error($sformatf("basis_size readback %h/%h (exp/act)", size, prdata));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_basis(logic [BASIS_W-1:0] size);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= BASIS_SIZE_ADDR;
        pwdata <= CFG_DATA_W'(size);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        check_basis(size);
    endtask

    function automatic logic signed [VAL_W-1:0] rand_value();
        logic [63:0] x;
        int r;
        x = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 45)
            return VAL_W'($signed(x[26:0]));
        if (r < 70)
            return VAL_W'($signed(x[33:0]));
        if (r < 90)
            return x[VAL_W-1:0];
        case (x[2:0])
            3'd0: return FIX_MAX;
            3'd1: return FIX_MIN;
            3'd2: return '0;
            3'd3: return -FIX_ONE;
            default: return FIX_ONE;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_index(int lim);
        int r;
        r = $urandom_range(0, 99);
        if (lim == 0 || r >= 92)
            return IDX_W'($urandom_range(0, MAX_BASIS - 1));
        if (r < 70)
            return hot_idx[$urandom_range(0, 5)];
        return IDX_W'($urandom_range(0, lim - 1));
    endfunction

    task automatic need_density(logic [IDX_W-1:0] r, c);
        if (!dens_set[{r, c}])
            issue_op(FUNC_WR_DENSITY, r, c, IDX_W'($urandom_range(0, 63)),
                     IDX_W'($urandom_range(0, 63)), rand_value());
    endtask

    task automatic need_fock(logic [IDX_W-1:0] r, c);
        if (!fock_set[{r, c}])
            issue_op(FUNC_WR_FOCK, r, c, IDX_W'($urandom_range(0, 63)),
                     IDX_W'($urandom_range(0, 63)), rand_value());
    endtask

    // mostly a small hot set of indices so integrals land on written entries
    task automatic run_random(int count);
        logic [1:0] op;
        logic [IDX_W-1:0] i, j, k, l;
        int r, lim, stop;
        stop = n_sent + count;
        lim = int'(basis_cfg) > MAX_BASIS ? MAX_BASIS : int'(basis_cfg);
        foreach (hot_idx[n])
            hot_idx[n] = IDX_W'(lim == 0 ? $urandom_range(0, 63) : $urandom_range(0, lim - 1));
        if (lim > 0) begin
            hot_idx[0] = '0;
            hot_idx[1] = IDX_W'(lim - 1);
        end
        while (n_sent < stop) begin
            r = $urandom_range(0, 99);
            op = r < 20 ? FUNC_WR_DENSITY : r < 35 ? FUNC_WR_FOCK :
                 r < 80 ? FUNC_CONTRACT : FUNC_RD_FOCK;
            i = pick_index(lim);
            j = pick_index(lim);
            k = pick_index(lim);
            l = pick_index(lim);
            if (op == FUNC_RD_FOCK && idx_valid(i) && idx_valid(j))
                need_fock(i, j);
            if (op == FUNC_CONTRACT && idx_valid(i) && idx_valid(j) && idx_valid(k)
                    && idx_valid(l)) begin
                need_density(k, l);
                need_density(i, l);
                need_fock(i, j);
                need_fock(j, k);
            end
            issue_op(op, i, j, k, l, rand_value());
        end
    endtask

    task automatic test_directed_corners();
        check_basis(BASIS_RESET);
        issue_op(FUNC_WR_DENSITY, 0, 0, 0, 0, FIX_MAX);
        issue_op(FUNC_WR_DENSITY, 63, 63, 63, 63, FIX_MIN);
        issue_op(FUNC_WR_FOCK, 0, 0, 0, 0, '0);
        issue_op(FUNC_RD_FOCK, 0, 0, 0, 0, '0);
        // all four indices equal: exchange hits the entry Coulomb just clipped
        issue_op(FUNC_CONTRACT, 0, 0, 0, 0, FIX_MAX);
        issue_op(FUNC_RD_FOCK, 0, 0, 0, 0, '0);
        issue_op(FUNC_WR_FOCK, 63, 63, 0, 0, FIX_MIN);
        issue_op(FUNC_CONTRACT, 63, 63, 63, 63, FIX_MIN);
        issue_op(FUNC_RD_FOCK, 63, 63, 63, 63, FIX_MAX);
        issue_op(FUNC_WR_DENSITY, 3, 4, 0, 0, FIX_ONE);
        issue_op(FUNC_WR_DENSITY, 1, 4, 0, 0, -(FIX_ONE >>> 1));
        issue_op(FUNC_WR_FOCK, 1, 2, 0, 0, 5 * FIX_ONE);
        issue_op(FUNC_WR_FOCK, 2, 3, 0, 0, -3);
        issue_op(FUNC_CONTRACT, 1, 2, 3, 4, 40'sh0000123457);
        issue_op(FUNC_RD_FOCK, 1, 2, 0, 0, '0);
        issue_op(FUNC_RD_FOCK, 2, 3, 0, 0, '0);
        // tiny integrals: floor rounding toward minus infinity
        issue_op(FUNC_CONTRACT, 1, 2, 3, 4, -1);
        issue_op(FUNC_CONTRACT, 1, 2, 3, 4, 1);
        issue_op(FUNC_RD_FOCK, 1, 2, 0, 0, '0);
        issue_op(FUNC_RD_FOCK, 2, 3, 0, 0, '0);
    endtask

    task automatic test_random_full_basis();
        run_random(560);
    endtask

    task automatic test_tiny_basis();
        set_basis(1);
        run_random(110);
        set_basis(2);
        run_random(90);
    endtask

    task automatic test_zero_basis();
        set_basis(0);
        run_random(50);
    endtask

    task automatic test_oversized_basis();
        set_basis(7'd127);
        run_random(200);
        set_basis(65);
        run_random(50);
    endtask

    task automatic test_partial_basis();
        set_basis(37);
        run_random(320);
        set_basis(BASIS_RESET);
        run_random(50);
    endtask

    initial begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        test_directed_corners();
        test_random_full_basis();
        test_tiny_basis();
        test_zero_basis();
        test_oversized_basis();
        test_partial_basis();
        drain();
        repeat (40) @(posedge clk);
        n_errors += pending_results.size();
        $display("Run covered %0d items, %0d results checked: %0d integrals, %0d Fock reads,",
                 n_items, n_checked, n_contract, n_reads);
        $display("%0d index errors and %0d clipped updates over basis sizes 64,1,2,0,127,65,37.",
                 n_idx_err, n_sat);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
sv/fcea_pkg.sv
sv/fock_coulomb_exchange_accumulate_core.sv
tb/testbench.sv
